[sv/rps_ca_pkg.sv]
package rps_ca_pkg;

    // grid geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WSZ_W      = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W      = $clog2(MAX_HEIGHT + 1);
    localparam int RST_SIZE   = 500;
    localparam int RST_W_USE  = (RST_SIZE > MAX_WIDTH) ? MAX_WIDTH : RST_SIZE;
    localparam int RST_H_USE  = (RST_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RST_SIZE;

    // field widths
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;
    localparam int DIR_W = 2;
    localparam int IN_W  = OP_W + ROW_W + COL_W + ST_W + DIR_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 2 * ST_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    // cell store: {generation, row, col}
    localparam int ADDR_W    = 1 + ROW_W + COL_W;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_SWAP   = 2'd2;

    // neighbor directions
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    localparam logic [ST_W-1:0] ST_MAX = 2'd2;

    // winner of (cell, neighbor)
    localparam logic [ST_W-1:0] WIN_TABLE [0:2][0:2] = '{
        '{2'd0, 2'd1, 2'd0},
        '{2'd1, 2'd1, 2'd2},
        '{2'd0, 2'd2, 2'd2}
    };

    function automatic logic [ST_W-1:0] clamp_state(input logic [ST_W-1:0] s);
        return (s > ST_MAX) ? ST_MAX : s;
    endfunction

endpackage

[sv/rps_ca_ram.sv]
module rps_ca_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-before-write on an address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

[sv/rps_automaton_cell_update.sv]
// Channel   Dir  Handshake               Payload
// s (item)  in   i_s_tvalid/o_s_tready   i_s_tdata: opcode, row, col, cell_value, direction
// m (res)   out  o_m_tvalid/i_m_tready   o_m_tdata: cell_state, new_state
// cfg       in   i_cfg_we                i_cfg_addr (register index), i_cfg_wdata
//
// One item per cycle sustained, unless a held result stalls the pipe. An accepted
// item loads the input stage, its RAM read then loads the RAM read stage, and its
// result then goes into the output register.
// The pace is set by the cell RAM: two reads and one write per cycle.
// After reset a clearing pass zeroes every cell of both generations, one cell a
// cycle; no item is taken meanwhile.
// A held result stalls the pipe only when the RAM stage also carries a result.
module rps_automaton_cell_update (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // [1:0] opcode, [10:2] row, [19:11] col, [21:20] cell_value, [23:22] direction
    input  logic [rps_ca_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [1:0] cell_state, [3:2] new_state, rest zero
    output logic [rps_ca_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                                  i_cfg_we,
    input  logic [rps_ca_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [rps_ca_pkg::CFG_W-1:0]          i_cfg_wdata
);

    import rps_ca_pkg::*;

    // ---------------------------------------------------------------- fields
    logic [OP_W-1:0]  in_op;
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    logic [ST_W-1:0]  in_val;
    logic [DIR_W-1:0] in_dir;

    assign in_op  = i_s_tdata[OP_W-1:0];
    assign in_row = i_s_tdata[OP_W +: ROW_W];
    assign in_col = i_s_tdata[OP_W+ROW_W +: COL_W];
    assign in_val = i_s_tdata[OP_W+ROW_W+COL_W +: ST_W];
    assign in_dir = i_s_tdata[OP_W+ROW_W+COL_W+ST_W +: DIR_W];

    // ---------------------------------------------------------------- config
    // Sizes are stored already clamped to 1..MAX.
    logic [WSZ_W-1:0] r_w_use, n_w_use;
    logic [HSZ_W-1:0] r_h_use, n_h_use;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_w_use = WSZ_W'(1);
            n_h_use = HSZ_W'(1);
        end else begin
            n_w_use = (int'(i_cfg_wdata) > MAX_WIDTH) ? WSZ_W'(MAX_WIDTH)
                                                       : WSZ_W'(i_cfg_wdata);
            n_h_use = (int'(i_cfg_wdata) > MAX_HEIGHT) ? HSZ_W'(MAX_HEIGHT)
                                                        : HSZ_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_use <= WSZ_W'(RST_W_USE);
            r_h_use <= HSZ_W'(RST_H_USE);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GRID_WIDTH:  r_w_use <= n_w_use;
                CFG_GRID_HEIGHT: r_h_use <= n_h_use;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- flow control
    logic r_s2_vld, r_s2_upd;
    logic r_out_vld;
    logic s2_res;
    logic adv;
    logic accept;

    // The whole pipe moves together; it stops only when a result would be
    // pushed onto a held one.
    assign s2_res     = r_s2_vld && r_s2_upd;
    assign adv        = !r_out_vld || i_m_tready || !s2_res;
    assign o_s_tready = adv && !r_clr_busy;
    assign accept     = i_s_tvalid && o_s_tready;

    // current generation flips on a swap transaction
    logic r_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= 1'b0;
        end else if (accept && (in_op == OP_SWAP)) begin
            r_cur <= ~r_cur;
        end
    end

    // ---------------------------------------------------------------- stage 0 decode
    logic             in_range, is_load, is_upd;
    logic [ROW_W-1:0] n_nrow;
    logic [COL_W-1:0] n_ncol;

    assign in_range = (HSZ_W'(in_row) < r_h_use) && (WSZ_W'(in_col) < r_w_use);
    assign is_load  = (in_op == OP_LOAD) && (in_val <= ST_MAX) && in_range;
    assign is_upd   = (in_op == OP_UPDATE) && in_range;

    // torus neighbor
    always_comb begin
        n_nrow = in_row;
        n_ncol = in_col;
        unique case (in_dir)
            DIR_UP:
                n_nrow = (in_row == '0) ? ROW_W'(r_h_use - 1'b1) : in_row - 1'b1;
            DIR_LEFT:
                n_ncol = (in_col == '0) ? COL_W'(r_w_use - 1'b1) : in_col - 1'b1;
            DIR_DOWN:
                n_nrow = ((HSZ_W'(in_row) + HSZ_W'(1)) >= r_h_use) ? '0 : in_row + 1'b1;
            DIR_RIGHT:
                n_ncol = ((WSZ_W'(in_col) + WSZ_W'(1)) >= r_w_use) ? '0 : in_col + 1'b1;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- stage 1
    // Only loads and updates that touch the grid go on; swaps and drops end here.
    logic             r_s1_vld, r_s1_upd, r_s1_buf;
    logic [ROW_W-1:0] r_s1_row, r_s1_nrow;
    logic [COL_W-1:0] r_s1_col, r_s1_ncol;
    logic [ST_W-1:0]  r_s1_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= accept && (is_load || is_upd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_upd  <= is_upd;
            r_s1_buf  <= r_cur;
            r_s1_row  <= in_row;
            r_s1_col  <= in_col;
            r_s1_nrow <= n_nrow;
            r_s1_ncol <= n_ncol;
            r_s1_val  <= in_val;
        end
    end

    logic [ADDR_W-1:0] s1_ra0, s1_ra1, s1_waddr;

    assign s1_ra0   = {r_s1_buf, r_s1_row, r_s1_col};
    assign s1_ra1   = {r_s1_buf, r_s1_nrow, r_s1_ncol};
    // loads write the current generation, updates the next one
    assign s1_waddr = r_s1_upd ? {~r_s1_buf, r_s1_row, r_s1_col} : s1_ra0;

    // ---------------------------------------------------------------- stage 2
    logic [ADDR_W-1:0] r_s2_waddr;
    logic [ST_W-1:0]   r_s2_val, r_s2_fdata;
    logic              r_s2_fwd0, r_s2_fwd1;
    logic [ST_W-1:0]   rd0, rd1, d0, d1, old_st, nb_st, win_st, s2_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // The RAM read issued from stage 1 misses the write that stage 2 makes in
    // the same cycle; that write is caught here and bypassed.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_upd   <= r_s1_upd;
            r_s2_waddr <= s1_waddr;
            r_s2_val   <= r_s1_val;
            r_s2_fwd0  <= r_s2_vld && (r_s2_waddr == s1_ra0);
            r_s2_fwd1  <= r_s2_vld && (r_s2_waddr == s1_ra1);
            r_s2_fdata <= s2_wdata;
        end
    end

    assign d0       = r_s2_fwd0 ? r_s2_fdata : rd0;
    assign d1       = r_s2_fwd1 ? r_s2_fdata : rd1;
    assign old_st   = clamp_state(d0);
    assign nb_st    = clamp_state(d1);
    assign win_st   = WIN_TABLE[old_st][nb_st];
    assign s2_wdata = r_s2_upd ? win_st : r_s2_val;

    // ---------------------------------------------------------------- cell RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ST_W-1:0]   ram_wdata;

    assign ram_we    = r_clr_busy || (adv && r_s2_vld);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s2_waddr;
    assign ram_wdata = r_clr_busy ? '0 : s2_wdata;

    rps_ca_ram #(
        .WIDTH (ST_W),
        .DEPTH (RAM_DEPTH)
    ) u_cell_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_re     (adv),
        .i_raddr0 (s1_ra0),
        .i_raddr1 (s1_ra1),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    // ---------------------------------------------------------------- output register
    logic [ST_W-1:0] r_out_cell, r_out_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= s2_res || (r_out_vld && !i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s2_res) begin
            r_out_cell <= old_st;
            r_out_new  <= win_st;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_new, r_out_cell});

    // ---------------------------------------------------------------- assertions
    a_no_take_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_s_tready
    ) else $error("item taken during clearing pass");

    a_no_write_when_frozen: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!adv && !r_clr_busy) |-> !ram_we
    ) else $error("cell RAM written while pipe is frozen");

    a_clear_writes_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (ram_we && (ram_wdata == '0))
    ) else $error("clearing pass wrote nonzero data");

    a_result_from_update: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(s2_res && adv)
    ) else $error("result without an update leaving the RAM stage");

endmodule
